// ===== rtl/tlc_pkg.sv =====
// Package for the two-level inclusive LRU tag store core.
// Holds geometry constants, register indexes and request/response structs.
`default_nettype none
package tlc_pkg;
   localparam int L1_SETS = 64;
   localparam int L1_WAYS = 2;
   localparam int L2_SETS = 256;
   localparam int L2_WAYS = 4;
   localparam int L1_SET_BITS = (L1_SETS > 1) ? $clog2(L1_SETS + 1) - 1 : 0;
   localparam int L2_SET_BITS = (L2_SETS > 1) ? $clog2(L2_SETS + 1) - 1 : 0;
   localparam int L1_WAY_BITS = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
   localparam int L2_WAY_BITS = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
   localparam int L1_IDX_BITS = (L1_SETS * L1_WAYS > 1) ? $clog2(L1_SETS * L1_WAYS) : 1;
   localparam int L2_IDX_BITS = (L2_SETS * L2_WAYS > 1) ? $clog2(L2_SETS * L2_WAYS) : 1;
   localparam int L1_DEPTH = L1_SETS * L1_WAYS;
   localparam int L2_DEPTH = L2_SETS * L2_WAYS;
   // tag, stamp, dirty, valid
   localparam int LINE_BITS = 66;

   localparam logic [2:0] REG_OFFSET_BITS = 3'd0;
   localparam logic [2:0] REG_L1_LATENCY  = 3'd1;
   localparam logic [2:0] REG_L2_LATENCY  = 3'd2;
   localparam logic [2:0] REG_MEM_LATENCY = 3'd3;
   localparam logic [2:0] REG_WRITE_ALLOC = 3'd4;

   localparam logic [1:0] OUT_L1_HIT  = 2'd0;
   localparam logic [1:0] OUT_L2_HIT  = 2'd1;
   localparam logic [1:0] OUT_MISS    = 2'd2;

   typedef struct packed {
      logic        action;
      logic [31:0] address;
   } req_type;

   typedef struct packed {
      logic [1:0]  outcome;
      logic [17:0] access_latency;
      logic [31:0] l1_misses;
      logic [31:0] l2_misses;
      logic [47:0] total_cycles;
   } rsp_type;
endpackage
`default_nettype wire

// ===== rtl/tlc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module tlc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   output logic      [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/two_level_inclusive_lru_cache_core.sv =====
// Top level of the two-level inclusive LRU tag store core.
// Depends on tlc_pkg and tlc_ram (tag, stamp, dirty and valid per way in RAM).
// Operation: once a request is accepted, each way read takes an address step
// and then a registered-data step, walking the L1 probe, L2 probe, L1 fill, L2
// refresh, L2 fill and L1 back-invalidate phases, then a report step. busy
// drops in the response cycle; no new request is accepted before then.
// Reset clears counters and stamp at once, then runs a clearing pass over both
// RAMs with busy high.
// The receiver cannot stall: rsp_valid pulses for one cycle.
`default_nettype none
module two_level_inclusive_lru_cache_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire tlc_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output tlc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_data
);
   import tlc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_P1_RD, S_P1_CK, S_P2_RD, S_P2_CK, S_F1_RD, S_F1_CK, S_F1_WR,
      S_R2_RD, S_R2_CK, S_F2_RD, S_F2_CK, S_F2_WR, S_D1_RD, S_D1_CK, S_DONE,
      S_CLR
   } state_type;

   state_type state_ff;
   logic [3:0]  offset_ff;
   logic [15:0] l1_lat_ff, l2_lat_ff, mem_lat_ff;
   logic        walloc_ff;
   logic [L2_IDX_BITS-1:0] clr_ff;
   logic [31:0] stamp_ff, m1_ff, m2_ff;
   logic [47:0] cyc_ff;
   logic        wr_ff;
   logic [31:0] addr_ff, vaddr_ff;
   logic [4:0]  way_ff;
   logic        found_ff;
   logic [4:0]  pick_ff;
   logic [31:0] min_ff;
   logic [1:0]  outcome_ff;
   logic [17:0] lat_ff;
   logic        vdirty_ff;

   // addressing RAMs
   logic                   r1_we, r2_we;
   logic [L1_IDX_BITS-1:0] r1_a;
   logic [L2_IDX_BITS-1:0] r2_a;
   logic [LINE_BITS-1:0]   r1_wd, r2_wd, r1_rd, r2_rd;

   tlc_ram #(.WIDTH(LINE_BITS), .DEPTH(L1_DEPTH)) u_l1 (
      .clock(clock), .wr_en(r1_we), .addr(r1_a), .wr_data(r1_wd), .rd_data(r1_rd));
   tlc_ram #(.WIDTH(LINE_BITS), .DEPTH(L2_DEPTH)) u_l2 (
      .clock(clock), .wr_en(r2_we), .addr(r2_a), .wr_data(r2_wd), .rd_data(r2_rd));

   // address being worked on: victim address in refresh and drop phases
   logic [31:0] cur_addr;
   logic [63:0] sh1, sh2;
   logic [31:0] set1, set2, tag1, tag2;
   logic [L1_IDX_BITS-1:0] idx1;
   logic [L2_IDX_BITS-1:0] idx2;
   logic [31:0] rd1_tag, rd2_tag, rd1_st, rd2_st;
   logic        rd1_dt, rd2_dt, rd1_vl, rd2_vl;
   logic [63:0] vrec1, vrec2;
   logic [31:0] new_stamp;

   always_comb begin
      cur_addr = (state_ff == S_R2_RD || state_ff == S_R2_CK || state_ff == S_D1_RD ||
                  state_ff == S_D1_CK) ? vaddr_ff : addr_ff;
      sh1  = {32'd0, cur_addr} >> offset_ff;
      set1 = sh1[31:0] & ((32'd1 << L1_SET_BITS) - 32'd1);
      tag1 = 32'(sh1 >> L1_SET_BITS);
      sh2  = {32'd0, cur_addr} >> offset_ff;
      set2 = sh2[31:0] & ((32'd1 << L2_SET_BITS) - 32'd1);
      tag2 = 32'(sh2 >> L2_SET_BITS);
      idx1 = L1_IDX_BITS'(set1 * L1_WAYS + 32'(way_ff));
      idx2 = L2_IDX_BITS'(set2 * L2_WAYS + 32'(way_ff));
      {rd1_tag, rd1_st, rd1_dt, rd1_vl} = r1_rd;
      {rd2_tag, rd2_st, rd2_dt, rd2_vl} = r2_rd;
      vrec1 = ({32'd0, rd1_tag} << (32'(offset_ff) + L1_SET_BITS)) |
              ({32'd0, set1} << offset_ff);
      vrec2 = ({32'd0, rd2_tag} << (32'(offset_ff) + L2_SET_BITS)) |
              ({32'd0, set2} << offset_ff);
      new_stamp = stamp_ff;
   end

   // RAM controls
   always_comb begin
      r1_we = 1'b0;
      r2_we = 1'b0;
      r1_a  = idx1;
      r2_a  = idx2;
      r1_wd = {tag1, new_stamp, wr_ff, 1'b1};
      r2_wd = {tag2, new_stamp, wr_ff, 1'b1};
      case (state_ff)
         S_CLR: begin
            r1_we = (32'(clr_ff) < L1_DEPTH);
            r2_we = 1'b1;
            r1_a  = L1_IDX_BITS'(clr_ff);
            r2_a  = clr_ff;
            r1_wd = '0;
            r2_wd = '0;
         end
         S_P1_CK: begin
            if (rd1_vl && rd1_tag == tag1) begin
               r1_we = 1'b1;
               r1_wd = {rd1_tag, new_stamp, rd1_dt | wr_ff, 1'b1};
            end
         end
         S_P2_CK: begin
            if (rd2_vl && rd2_tag == tag2) begin
               r2_we = 1'b1;
               r2_wd = {rd2_tag, new_stamp, rd2_dt | wr_ff, 1'b1};
            end
         end
         S_R2_CK: begin
            if (rd2_vl && rd2_tag == tag2) begin
               r2_we = 1'b1;
               r2_wd = {rd2_tag, new_stamp + 32'd1, 1'b1, 1'b1};
            end
         end
         S_F1_WR: begin
            r1_we = 1'b1;
            r1_a  = L1_IDX_BITS'(set1 * L1_WAYS + 32'(pick_ff));
         end
         S_F2_WR: begin
            r2_we = 1'b1;
            r2_a  = L2_IDX_BITS'(set2 * L2_WAYS + 32'(pick_ff));
         end
         S_D1_CK: begin
            // drop matches tag regardless of valid
            if (rd1_tag == tag1) begin
               r1_we = 1'b1;
               r1_wd = {rd1_tag, rd1_st, rd1_dt, 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   logic [48:0] cyc_sum;
   always_comb cyc_sum = {1'b0, cyc_ff} + 49'(lat_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         clr_ff     <= '0;
         offset_ff  <= 4'd2;
         l1_lat_ff  <= 16'd1;
         l2_lat_ff  <= 16'd10;
         mem_lat_ff <= 16'd100;
         walloc_ff  <= 1'b1;
         stamp_ff   <= '0;
         m1_ff      <= '0;
         m2_ff      <= '0;
         cyc_ff     <= '0;
         rsp_valid  <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               REG_OFFSET_BITS: offset_ff  <= csr_data[3:0];
               REG_L1_LATENCY:  l1_lat_ff  <= csr_data;
               REG_L2_LATENCY:  l2_lat_ff  <= csr_data;
               REG_MEM_LATENCY: mem_lat_ff <= csr_data;
               REG_WRITE_ALLOC: walloc_ff  <= csr_data[0];
               default: begin
               end
            endcase
         end
         case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == L2_DEPTH - 1) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  wr_ff    <= req_data.action;
                  addr_ff  <= req_data.address;
                  stamp_ff <= stamp_ff + 32'd2;
                  way_ff   <= '0;
                  state_ff <= S_P1_RD;
               end
            end
            S_P1_RD: state_ff <= S_P1_CK;
            S_P1_CK: begin
               if (rd1_vl && rd1_tag == tag1) begin
                  outcome_ff <= OUT_L1_HIT;
                  lat_ff     <= 18'(l1_lat_ff);
                  state_ff   <= S_DONE;
               end else if (32'(way_ff) == L1_WAYS - 1) begin
                  if (m1_ff != '1) m1_ff <= m1_ff + 32'd1;
                  way_ff   <= '0;
                  state_ff <= S_P2_RD;
               end else begin
                  way_ff   <= way_ff + 5'd1;
                  state_ff <= S_P1_RD;
               end
            end
            S_P2_RD: state_ff <= S_P2_CK;
            S_P2_CK: begin
               if ((rd2_vl && rd2_tag == tag2) || 32'(way_ff) == L2_WAYS - 1) begin
                  way_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= (wr_ff && !walloc_ff) ? S_DONE : S_F1_RD;
                  if (rd2_vl && rd2_tag == tag2) begin
                     outcome_ff <= OUT_L2_HIT;
                     lat_ff     <= 18'(l1_lat_ff) + 18'(l2_lat_ff);
                  end else begin
                     if (m2_ff != '1) m2_ff <= m2_ff + 32'd1;
                     outcome_ff <= OUT_MISS;
                     lat_ff <= 18'(l1_lat_ff) + 18'(l2_lat_ff) + 18'(mem_lat_ff);
                  end
               end else begin
                  way_ff   <= way_ff + 5'd1;
                  state_ff <= S_P2_RD;
               end
            end
            S_F1_RD: state_ff <= S_F1_CK;
            S_F1_CK: begin
               // take the first free way, else track the least stamp
               if (!rd1_vl) begin
                  pick_ff  <= way_ff;
                  found_ff <= 1'b1;
                  state_ff <= S_F1_WR;
               end else begin
                  if (way_ff == '0 || rd1_st < min_ff) begin
                     min_ff    <= rd1_st;
                     pick_ff   <= way_ff;
                     vaddr_ff  <= vrec1[31:0];
                     vdirty_ff <= rd1_dt;
                  end
                  if (32'(way_ff) == L1_WAYS - 1) begin
                     state_ff <= S_F1_WR;
                  end else begin
                     way_ff   <= way_ff + 5'd1;
                     state_ff <= S_F1_RD;
                  end
               end
            end
            S_F1_WR: begin
               way_ff <= '0;
               if (!found_ff && vdirty_ff) state_ff <= S_R2_RD;
               else if (outcome_ff == OUT_MISS) begin
                  found_ff <= 1'b0;
                  state_ff <= S_F2_RD;
               end else state_ff <= S_DONE;
            end
            S_R2_RD: state_ff <= S_R2_CK;
            S_R2_CK: begin
               if (32'(way_ff) == L2_WAYS - 1) begin
                  way_ff   <= '0;
                  found_ff <= 1'b0;
                  state_ff <= (outcome_ff == OUT_MISS) ? S_F2_RD : S_DONE;
               end else begin
                  way_ff   <= way_ff + 5'd1;
                  state_ff <= S_R2_RD;
               end
            end
            S_F2_RD: state_ff <= S_F2_CK;
            S_F2_CK: begin
               if (!rd2_vl) begin
                  pick_ff  <= way_ff;
                  found_ff <= 1'b1;
                  state_ff <= S_F2_WR;
               end else begin
                  if (way_ff == '0 || rd2_st < min_ff) begin
                     min_ff   <= rd2_st;
                     pick_ff  <= way_ff;
                     vaddr_ff <= vrec2[31:0];
                  end
                  if (32'(way_ff) == L2_WAYS - 1) begin
                     state_ff <= S_F2_WR;
                  end else begin
                     way_ff   <= way_ff + 5'd1;
                     state_ff <= S_F2_RD;
                  end
               end
            end
            S_F2_WR: begin
               way_ff   <= '0;
               state_ff <= found_ff ? S_DONE : S_D1_RD;
            end
            S_D1_RD: state_ff <= S_D1_CK;
            S_D1_CK: begin
               if (32'(way_ff) == L1_WAYS - 1) state_ff <= S_DONE;
               else begin
                  way_ff   <= way_ff + 5'd1;
                  state_ff <= S_D1_RD;
               end
            end
            S_DONE: begin
               cyc_ff    <= cyc_sum[48] ? '1 : cyc_sum[47:0];
               rsp_valid <= 1'b1;
               rsp_data.outcome        <= outcome_ff;
               rsp_data.access_latency <= lat_ff;
               rsp_data.l1_misses      <= m1_ff;
               rsp_data.l2_misses      <= m2_ff;
               rsp_data.total_cycles   <= cyc_sum[48] ? '1 : cyc_sum[47:0];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

// ===== bench/tlc_checker.sv =====
// Checker for the two-level inclusive LRU tag store core: watches the request,
// response and register ports, predicts each response and compares it.
// Depends on tlc_pkg for the request/response structs and geometry.
module tlc_checker
   import tlc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire logic       busy,
   input  wire req_type    req_data,
   input  wire logic       rsp_valid,
   input  wire rsp_type    rsp_data,
   input  wire logic       csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic [15:0] csr_data,
   output int              fail_count,
   output int              outstanding
);
   // index 0 is L1, index 1 is L2
   logic [31:0] tag_mem   [2][L2_DEPTH];
   logic [31:0] stamp_mem [2][L2_DEPTH];
   bit          valid_mem [2][L2_DEPTH];
   bit          dirty_mem [2][L2_DEPTH];

   logic [31:0] stamp_now;
   logic [31:0] l1_miss_cnt;
   logic [31:0] l2_miss_cnt;
   logic [47:0] cycle_cnt;

   logic [3:0]  ofs_bits;
   logic [15:0] lat_l1;
   logic [15:0] lat_l2;
   logic [15:0] lat_mem;
   bit          wr_alloc;

   rsp_type     expected_rsps[$];

   initial fail_count = 0;
   initial outstanding = 0;

   function automatic int unsigned level_set_bits(int lv);
      return (lv == 0) ? L1_SET_BITS : L2_SET_BITS;
   endfunction

   function automatic int unsigned level_ways(int lv);
      return (lv == 0) ? L1_WAYS : L2_WAYS;
   endfunction

   function automatic int unsigned set_base(int lv, logic [31:0] addr);
      logic [63:0] a;
      a = {32'd0, addr} >> ofs_bits;
      return int'(a & ((64'd1 << level_set_bits(lv)) - 1)) * level_ways(lv);
   endfunction

   function automatic logic [31:0] tag_from(int lv, logic [31:0] addr);
      logic [63:0] a;
      a = {32'd0, addr} >> (ofs_bits + level_set_bits(lv));
      return a[31:0];
   endfunction

   function automatic bit lookup(int lv, logic [31:0] addr, bit wr);
      int unsigned base;
      base = set_base(lv, addr);
      for (int w = 0; w < level_ways(lv); w++) begin
         if (valid_mem[lv][base+w] && tag_mem[lv][base+w] == tag_from(lv, addr)) begin
            stamp_mem[lv][base+w] = stamp_now;
            if (wr) dirty_mem[lv][base+w] = 1'b1;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Returns 1 when a valid line is displaced; victim address and dirty out.
   function automatic bit allocate_line(int lv, logic [31:0] addr, bit wr,
                                        output logic [31:0] vaddr, output bit vdirty);
      int unsigned base, pick, set_no;
      bit          evict;
      logic [31:0] least;
      logic [63:0] va;
      base = set_base(lv, addr);
      set_no = base / level_ways(lv);
      pick = 0;
      evict = 1'b1;
      vaddr = '0;
      vdirty = 1'b0;
      for (int w = 0; w < level_ways(lv); w++) begin
         if (evict && !valid_mem[lv][base+w]) begin
            pick = w;
            evict = 1'b0;
         end
      end
      if (evict) begin
         least = stamp_mem[lv][base];
         for (int w = 1; w < level_ways(lv); w++) begin
            if (stamp_mem[lv][base+w] < least) begin
               least = stamp_mem[lv][base+w];
               pick = w;
            end
         end
         va = ({32'd0, tag_mem[lv][base+pick]} << (ofs_bits + level_set_bits(lv)))
              | (64'(set_no) << ofs_bits);
         vaddr = va[31:0];
         vdirty = dirty_mem[lv][base+pick];
      end
      tag_mem[lv][base+pick] = tag_from(lv, addr);
      valid_mem[lv][base+pick] = 1'b1;
      dirty_mem[lv][base+pick] = wr;
      stamp_mem[lv][base+pick] = stamp_now;
      return evict;
   endfunction

   function automatic rsp_type access(req_type r);
      rsp_type     p;
      logic [31:0] lat;
      logic [31:0] va;
      bit          vd;
      bit          wr;
      wr = r.action;
      stamp_now = stamp_now + 32'd2;
      if (lookup(0, r.address, wr)) begin
         p.outcome = OUT_L1_HIT;
         lat = lat_l1;
      end else begin
         if (l1_miss_cnt != '1) l1_miss_cnt++;
         if (lookup(1, r.address, wr)) begin
            p.outcome = OUT_L2_HIT;
            lat = lat_l1 + lat_l2;
         end else begin
            if (l2_miss_cnt != '1) l2_miss_cnt++;
            p.outcome = OUT_MISS;
            lat = lat_l1 + lat_l2 + lat_mem;
         end
         if (!(wr && !wr_alloc)) begin
            // dirty L1 victim: refresh its L2 copy one stamp later, mark dirty
            if (allocate_line(0, r.address, wr, va, vd) && vd) begin
               for (int w = 0; w < L2_WAYS; w++) begin
                  if (valid_mem[1][set_base(1, va)+w]
                      && tag_mem[1][set_base(1, va)+w] == tag_from(1, va)) begin
                     stamp_mem[1][set_base(1, va)+w] = stamp_now + 32'd1;
                     dirty_mem[1][set_base(1, va)+w] = 1'b1;
                  end
               end
            end
            // L2 victim: back-invalidate matching L1 ways (tag match only)
            if (p.outcome == OUT_MISS && allocate_line(1, r.address, wr, va, vd)) begin
               for (int w = 0; w < L1_WAYS; w++) begin
                  if (tag_mem[0][set_base(0, va)+w] == tag_from(0, va))
                     valid_mem[0][set_base(0, va)+w] = 1'b0;
               end
            end
         end
      end
      if ({16'd0, cycle_cnt} > 64'hFFFF_FFFF_FFFF - lat) cycle_cnt = '1;
      else cycle_cnt = cycle_cnt + lat;
      p.access_latency = lat[17:0];
      p.l1_misses = l1_miss_cnt;
      p.l2_misses = l2_miss_cnt;
      p.total_cycles = cycle_cnt;
      return p;
   endfunction

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("[%0t] mismatch %s: got %0h, want %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int lv = 0; lv < 2; lv++) begin
            for (int i = 0; i < L2_DEPTH; i++) begin
               tag_mem[lv][i] = '0;
               stamp_mem[lv][i] = '0;
               valid_mem[lv][i] = 1'b0;
               dirty_mem[lv][i] = 1'b0;
            end
         end
         stamp_now = '0;
         l1_miss_cnt = '0;
         l2_miss_cnt = '0;
         cycle_cnt = '0;
         ofs_bits = 4'd2;
         lat_l1 = 16'd1;
         lat_l2 = 16'd10;
         lat_mem = 16'd100;
         wr_alloc = 1'b1;
         expected_rsps.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_OFFSET_BITS: ofs_bits = csr_data[3:0];
               REG_L1_LATENCY:  lat_l1 = csr_data;
               REG_L2_LATENCY:  lat_l2 = csr_data;
               REG_MEM_LATENCY: lat_mem = csr_data;
               REG_WRITE_ALLOC: wr_alloc = csr_data[0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report("unexpected response", rsp_data.total_cycles, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.outcome !== want.outcome)
                  report("outcome", rsp_data.outcome, want.outcome);
               if (rsp_data.access_latency !== want.access_latency)
                  report("access_latency", rsp_data.access_latency, want.access_latency);
               if (rsp_data.l1_misses !== want.l1_misses)
                  report("l1_misses", rsp_data.l1_misses, want.l1_misses);
               if (rsp_data.l2_misses !== want.l2_misses)
                  report("l2_misses", rsp_data.l2_misses, want.l2_misses);
               if (rsp_data.total_cycles !== want.total_cycles)
                  report("total_cycles", rsp_data.total_cycles, want.total_cycles);
            end
         end
         if (start && !busy) expected_rsps.insert(expected_rsps.size(), access(req_data));
      end
      outstanding = expected_rsps.size();
   end
endmodule

// ===== bench/tb_top.sv =====
// Top of the regression for the two-level inclusive LRU tag store core:
// drives requests and register writes, gives the verdict.
// Depends on tlc_pkg, the core and tlc_checker.
module tb_top;
   import tlc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   req_type     req_data = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = REG_OFFSET_BITS;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          outstanding;
   int          cycle_count = 0;
   logic [3:0]  cur_ofs = 4'd2;
   bit          no_gaps;

   localparam int CYCLE_LIMIT = 800000;

   always #4 clock = ~clock;

   two_level_inclusive_lru_cache_core dut (
      .clock, .reset, .start, .req_data, .busy, .rsp_valid, .rsp_data,
      .csr_write, .csr_index, .csr_data
   );

   tlc_checker u_checker (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_write, .csr_index, .csr_data, .fail_count, .outstanding
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("two_level_inclusive_lru_cache_core regression: fail");
         $finish;
      end
   end

   // Hold start until accepted, then idle for a random gap.
   task automatic send(bit act, logic [31:0] addr);
      int gap;
      start <= 1'b1;
      req_data <= '{action: act, address: addr};
      do @(posedge clock); while (busy);
      gap = $urandom_range(0, 99);
      if (no_gaps || gap < 45) gap = 0;
      else if (gap < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx == REG_OFFSET_BITS) cur_ofs = val[3:0];
      @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_phase(logic [15:0] ofs, logic [15:0] l1, logic [15:0] l2,
                            logic [15:0] mem, logic [15:0] wa);
      drain();
      write_reg(REG_OFFSET_BITS, ofs);
      write_reg(REG_L1_LATENCY, l1);
      write_reg(REG_L2_LATENCY, l2);
      write_reg(REG_MEM_LATENCY, mem);
      write_reg(REG_WRITE_ALLOC, wa);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly a few tags over a few sets so hits and evictions are common.
   function automatic logic [31:0] pick_address();
      logic [63:0] a;
      if ($urandom_range(0, 9) < 2) return $urandom;
      a = (64'($urandom_range(0, 11)) << (cur_ofs + L2_SET_BITS))
          | (64'($urandom_range(0, 3)) << cur_ofs)
          | (64'($urandom) & ((64'd1 << cur_ofs) - 1));
      return a[31:0];
   endfunction

   task automatic random_requests(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         send(1'($urandom_range(0, 1)), pick_address());
      end
   endtask

   initial begin
      no_gaps = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, then one L1/L2 set driven through eviction
      send(1'b0, 32'h0000_0000);
      send(1'b0, 32'h0000_0000);
      send(1'b1, 32'hFFFF_FFFF);
      send(1'b0, 32'hFFFF_FFFF);
      send(1'b1, 32'h0000_0000);
      for (int t = 1; t <= 6; t++) send(1'b0, 32'(t) << 10);
      send(1'b0, 32'h0000_0000);
      send(1'b1, 32'h0000_0400);
      send(1'b0, 32'h0000_1C00);
      send(1'b0, 32'h0000_2000);
      send(1'b0, 32'h0000_0400);
      send(1'b0, 32'h0000_0800);
      set_phase(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      send(1'b1, 32'h0000_5000);
      send(1'b1, 32'h0000_5000);
      send(1'b0, 32'h0000_5000);
      send(1'b1, 32'h0000_5000);
      random_requests(250);

      set_phase(16'd8, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
      random_requests(250);
      set_phase(16'd15, 16'd3, 16'd7, 16'd20, 16'd0);
      random_requests(250);
      set_phase(16'd5, 16'($urandom), 16'($urandom), 16'($urandom), 16'd1);
      random_requests(250);
      set_phase(16'd1, 16'd2, 16'd0, 16'hFFFF, 16'd0);
      random_requests(250);
      set_phase(16'd2, 16'd1, 16'd10, 16'd100, 16'd1);
      random_requests(330);

      drain();
      if (fail_count == 0) begin
         $display("two_level_inclusive_lru_cache_core regression: pass");
      end else begin
         $display("two_level_inclusive_lru_cache_core regression: fail");
      end
      $finish;
   end
endmodule
